// File: sv/ofsr_pkg.sv
package ofsr_pkg;

    localparam int unsigned F64_W      = 64;
    localparam int unsigned EXP_W      = 11;
    localparam int unsigned FRAC_W     = 52;
    localparam int unsigned CCOUNT_W   = 16;
    localparam int unsigned ECOUNT_W   = 32;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 32;
    // Mantissa with hidden bit and guard, round and sticky bits.
    localparam int unsigned WORK_W     = 56;

    localparam logic [F64_W-1:0] QUIET_BIT   = 64'h0008_0000_0000_0000;
    localparam logic [F64_W-1:0] DEFAULT_NAN = 64'h7FF8_0000_0000_0000;
    localparam logic [F64_W-1:0] POS_INF     = 64'h7FF0_0000_0000_0000;

    localparam logic [1:0] OP_SUM  = 2'd0;
    localparam logic [2:0] DT_F64  = 3'd5;

    localparam logic [1:0] OP_KIND_RST  = OP_SUM;
    localparam logic [2:0] DATA_KIND_RST = DT_F64;
    localparam logic [CCOUNT_W-1:0] CCOUNT_RST = 16'd2;
    localparam logic [ECOUNT_W-1:0] ECOUNT_RST = 32'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OP_KIND   = 2'd0,
        REG_DATA_KIND = 2'd1,
        REG_CCOUNT    = 2'd2,
        REG_ECOUNT    = 2'd3
    } t_cfg_idx;

    function automatic logic is_nan(input logic [F64_W-1:0] b);
        return b[62:0] > POS_INF[62:0];
    endfunction

    // Count leading zeros of the working mantissa; all zeros gives WORK_W.
    function automatic logic [5:0] lzc56(input logic [WORK_W-1:0] v);
        logic [5:0] n;
        logic       found;
        n     = 6'(WORK_W);
        found = 1'b0;
        for (int i = WORK_W - 1; i >= 0; i--) begin
            if (!found && v[i]) begin
                n     = 6'(WORK_W - 1 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

endpackage

// File: sv/ofsr_add.sv
module ofsr_add
    import ofsr_pkg::*;
(
    input  logic [F64_W-1:0] i_a,
    input  logic [F64_W-1:0] i_b,
    output logic [F64_W-1:0] o_sum
);

    logic             a_inf, b_inf;
    logic             swap;
    logic [F64_W-1:0] big, sml;
    logic [EXP_W-1:0] e_big, e_sml;
    logic [52:0]      m_big, m_sml;
    logic [EXP_W-1:0] d;
    logic [5:0]       dcap;
    logic [111:0]     sh;
    logic [WORK_W-1:0] al;
    logic             sub;
    logic [WORK_W:0]  s;
    logic             r_sign;
    logic [11:0]      e0;
    logic [WORK_W-1:0] n0;
    logic [5:0]       lz, shamt;
    logic [11:0]      e_lim;
    logic [WORK_W-1:0] m;
    logic [11:0]      e1;
    logic [EXP_W-1:0] field;
    logic             inc;
    logic [62:0]      packed_v;

    always_comb begin
        a_inf = (i_a[62:0] == POS_INF[62:0]);
        b_inf = (i_b[62:0] == POS_INF[62:0]);

        swap  = i_b[62:0] > i_a[62:0];
        big   = swap ? i_b : i_a;
        sml   = swap ? i_a : i_b;
        e_big = (big[62:52] == '0) ? 11'd1 : big[62:52];
        e_sml = (sml[62:52] == '0) ? 11'd1 : sml[62:52];
        m_big = {big[62:52] != '0, big[51:0]};
        m_sml = {sml[62:52] != '0, sml[51:0]};

        // Align the smaller operand and fold the lost bits into sticky.
        d    = e_big - e_sml;
        dcap = (d > 11'd63) ? 6'd63 : d[5:0];
        sh   = {m_sml, 59'd0} >> dcap;
        al   = {sh[111:57], sh[56] | (|sh[55:0])};

        sub = big[63] ^ sml[63];
        if (sub) begin
            s = {1'b0, m_big, 3'b000} - {1'b0, al};
        end else begin
            s = {1'b0, m_big, 3'b000} + {1'b0, al};
        end

        r_sign = (sub && s == '0) ? 1'b0 : big[63];

        // Normalize: carry out shifts right once, else shift left,
        // stopping at the subnormal floor.
        if (s[WORK_W]) begin
            n0 = {s[WORK_W:2], s[1] | s[0]};
            e0 = {1'b0, e_big} + 12'd1;
        end else begin
            n0 = s[WORK_W-1:0];
            e0 = {1'b0, e_big};
        end
        lz    = lzc56(n0);
        e_lim = e0 - 12'd1;
        shamt = ({6'd0, lz} > e_lim) ? e_lim[5:0] : lz;
        m     = n0 << shamt;
        e1    = e0 - {6'd0, shamt};
        field = m[WORK_W-1] ? e1[EXP_W-1:0] : '0;

        // Round to nearest even; the carry rolls into the exponent field.
        inc      = m[2] & (m[1] | m[0] | m[3]);
        packed_v = {field, m[54:3]} + 63'(inc);

        if (is_nan(i_a)) begin
            o_sum = i_a | QUIET_BIT;
        end else if (is_nan(i_b)) begin
            o_sum = i_b | QUIET_BIT;
        end else if (a_inf && b_inf && (i_a[63] != i_b[63])) begin
            o_sum = DEFAULT_NAN;
        end else if (a_inf) begin
            o_sum = i_a;
        end else if (b_inf) begin
            o_sum = i_b;
        end else if (e1 >= 12'd2047) begin
            o_sum = {r_sign, POS_INF[62:0]};
        end else begin
            o_sum = {r_sign, packed_v};
        end
    end

endmodule

// File: sv/ordered_f64_sum_reduction.sv
// Ordered binary64 sum reduction. Feed contributor values element by element;
// each word is held in an input register, then one binary64 add with
// round-to-nearest-even folds it into the running sum, so the block takes
// one word per cycle for as long as the result side keeps up. A result word
// (sum, status, final-element flag) is registered when the last contributor
// of an element leaves the input register and sits in an output register
// until taken. The dependent add of the running sum sets this rate. Modes
// other than sum on binary64 still count words and return a zero sum with
// status 1. Write configuration only while idle.
module ordered_f64_sum_reduction
    import ofsr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [F64_W-1:0]      i_operand_value,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [F64_W-1:0]      o_sum_value,
    output logic                  o_status_code,
    output logic                  o_final_element
);

    logic [1:0]          r_op_kind;
    logic [2:0]          r_data_kind;
    logic [CCOUNT_W-1:0] r_ccount;
    logic [ECOUNT_W-1:0] r_ecount;

    logic                r_in_vld;
    logic [F64_W-1:0]    r_in_val;
    logic [F64_W-1:0]    r_sum;
    logic [CCOUNT_W-1:0] r_cidx;
    logic [ECOUNT_W-1:0] r_eidx;
    logic                r_out_vld;

    logic [F64_W-1:0]    add_res;
    logic [F64_W-1:0]    n_sum;
    logic [CCOUNT_W:0]   cc_eff;
    logic [ECOUNT_W:0]   ec_eff;
    logic                elem_end;
    logic                last_elem;
    logic                supported;
    logic                out_free;
    logic                adv;

    // Configuration writes take effect at once.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op_kind   <= OP_KIND_RST;
            r_data_kind <= DATA_KIND_RST;
            r_ccount    <= CCOUNT_RST;
            r_ecount    <= ECOUNT_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                REG_OP_KIND:   r_op_kind   <= i_cfg_data[1:0];
                REG_DATA_KIND: r_data_kind <= i_cfg_data[2:0];
                REG_CCOUNT:    r_ccount    <= i_cfg_data[CCOUNT_W-1:0];
                REG_ECOUNT:    r_ecount    <= i_cfg_data[ECOUNT_W-1:0];
                default: ;
            endcase
        end
    end

    ofsr_add u_add (
        .i_a   (r_sum),
        .i_b   (r_in_val),
        .o_sum (add_res)
    );

    always_comb begin
        // Zero counts stand for the full range.
        cc_eff    = (r_ccount == '0) ? {1'b1, {CCOUNT_W{1'b0}}} : {1'b0, r_ccount};
        ec_eff    = (r_ecount == '0) ? {1'b1, {ECOUNT_W{1'b0}}} : {1'b0, r_ecount};
        elem_end  = ({1'b0, r_cidx} + 1'b1) >= cc_eff;
        last_elem = ({1'b0, r_eidx} + 1'b1) >= ec_eff;
        supported = (r_op_kind == OP_SUM) && (r_data_kind == DT_F64);
        // First contributor loads bit for bit, later ones add.
        n_sum     = (r_cidx == '0) ? r_in_val : add_res;
        out_free  = !r_out_vld || !i_stall;
        adv       = r_in_vld && out_free;
        o_stall   = r_in_vld && !out_free;
    end

    // Input register: load a new word whenever it is empty or the held one moves on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_stall) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_val <= i_operand_value;
        end
    end

    // Running sum and counters advance once per consumed word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_cidx <= '0;
            r_eidx <= '0;
        end else if (adv) begin
            r_sum <= n_sum;
            if (elem_end) begin
                r_cidx <= '0;
                r_eidx <= last_elem ? '0 : r_eidx + 1'b1;
            end else begin
                r_cidx <= r_cidx + 1'b1;
            end
        end
    end

    // Output register: hold the result word until it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv && elem_end) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && elem_end) begin
            o_sum_value     <= supported ? n_sum : '0;
            o_status_code   <= !supported;
            o_final_element <= last_elem;
        end
    end

    assign o_valid = r_out_vld;

    a_end_clears_cidx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && elem_end) |=> (r_cidx == '0))
        else $error("contributor index not cleared at element end");

    a_end_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && elem_end) |=> r_out_vld)
        else $error("element end did not produce a result word");

    a_stall_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_vld && r_out_vld && i_stall))
        else $error("input stalled without a blocked result");

    a_hold_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(r_sum))
        else $error("running sum changed without a consumed word");

endmodule
